/* hdl/snbd_pkg.sv */
// Shared types, constant tables and band decoders for the scrolling bar display.
package snbd_pkg;

  localparam int unsigned NumCols  = 8;
  localparam int unsigned ColW     = $clog2(NumCols);
  localparam int unsigned PixCnt   = NumCols * NumCols;
  localparam int unsigned PixCntW  = $clog2(PixCnt);
  localparam int unsigned HeightW  = 3;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned FreqW    = 16;

  // action codes
  localparam logic ActNote  = 1'b0;
  localparam logic ActClear = 1'b1;

  // colour style codes
  localparam logic StyleBand = 1'b0;
  localparam logic StyleGrad = 1'b1;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  // green base of the gradient, indexed by height above floor (7 - y)
  localparam logic [ChanW-1:0] GradGreen [NumCols] = '{
    8'd255, 8'd222, 8'd190, 8'd157, 8'd121, 8'd80, 8'd41, 8'd1
  };

  // brightness ramp along x: 170 + x*80/7
  localparam logic [ChanW-1:0] LumRamp [NumCols] = '{
    8'd170, 8'd181, 8'd192, 8'd204, 8'd215, 8'd227, 8'd238, 8'd250
  };

  function automatic logic [HeightW-1:0] band_height(input logic [FreqW-1:0] f);
    logic [HeightW-1:0] h;
    if (f == '0)              h = 3'd0;
    else if (f < 16'd300)     h = 3'd2;
    else if (f < 16'd400)     h = 3'd3;
    else if (f < 16'd500)     h = 3'd4;
    else if (f < 16'd600)     h = 3'd5;
    else if (f < 16'd700)     h = 3'd6;
    else                      h = 3'd7;
    return h;
  endfunction

  function automatic rgb_t band_color(input logic [FreqW-1:0] f);
    rgb_t c;
    if (f == '0)              c = '{8'd0,   8'd0,   8'd0};
    else if (f < 16'd300)     c = '{8'd255, 8'd0,   8'd0};
    else if (f < 16'd350)     c = '{8'd255, 8'd127, 8'd0};
    else if (f < 16'd400)     c = '{8'd255, 8'd255, 8'd0};
    else if (f < 16'd450)     c = '{8'd0,   8'd255, 8'd0};
    else if (f < 16'd550)     c = '{8'd0,   8'd0,   8'd255};
    else                      c = '{8'd75,  8'd0,   8'd130};
    return c;
  endfunction

endpackage

/* hdl/scrolling_note_bar_display.sv */
// Top level of the scrolling 8x8 note bar display: column store, pixel sequencer, output register.
//
// Usage
// - Input channel (in_valid_i / in_stall_o, action_i, note_freq_i): one word per note.
//   A note word shifts the eight column heights right, puts the band height of
//   note_freq_i in column 0 and then streams the whole 8x8 frame. A clear word
//   zeroes all heights and produces no pixels.
// - Output channel (out_valid_o / out_stall_i): 64 pixel words per note, in raster
//   order (row 0 at the top, column 0 first in each row); frame_end_o marks the last.
// - Configuration: cfg_we_i writes cfg_wdata_i into the colour style register
//   (0 band colour, 1 height gradient with x brightness). Write only while idle.
// Timing
// - The pixel counter walks the frame one pixel a cycle while the receiver does
//   not stall, through the shared gradient multiplier; the first pixel enters the
//   output register after the accepted note has set the sequencer busy.
// - in_stall_o is high while the counter walks the frame, so a note blocks the
//   next word until its last pixel enters the output register; a clear does not.
// - A receiver stall freezes the counter and holds the pending pixel word.
// Reset clears the heights, the colour style, the sequencer and the output valid.
module scrolling_note_bar_display (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        action_i,
  input  logic [snbd_pkg::FreqW-1:0]  note_freq_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [snbd_pkg::ColW-1:0]   pix_x_o,
  output logic [snbd_pkg::ColW-1:0]   pix_y_o,
  output logic [snbd_pkg::ChanW-1:0]  red_o,
  output logic [snbd_pkg::ChanW-1:0]  green_o,
  output logic [snbd_pkg::ChanW-1:0]  blue_o,
  output logic                        frame_end_o
);
  import snbd_pkg::*;

  logic [HeightW-1:0] heights_q [NumCols];
  logic               style_q;
  rgb_t               note_col_q;
  logic               busy_q;
  logic [PixCntW-1:0] cnt_q;

  logic               out_valid_q;
  logic [ColW-1:0]    pix_x_q, pix_y_q;
  rgb_t               pix_col_q;
  logic               frame_end_q;

  logic               in_acc;
  logic               advance;
  logic [ColW-1:0]    cur_x, cur_y;
  logic               lit;
  rgb_t               grad_col;
  rgb_t               pix_col_d;

  assign in_acc  = in_valid_i && !busy_q;
  // next pixel may enter the output register when it is empty or being taken
  assign advance = busy_q && (!out_valid_q || !out_stall_i);

  assign cur_x = cnt_q[ColW-1:0];
  assign cur_y = cnt_q[PixCntW-1:ColW];
  assign lit   = heights_q[cur_x] > ~cur_y;

  snbd_grad u_grad (
    .x_i     (cur_x),
    .y_i     (cur_y),
    .color_o (grad_col)
  );

  always_comb begin
    pix_col_d = '0;
    if (lit) begin
      pix_col_d = (style_q == StyleGrad) ? grad_col : note_col_q;
    end
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      style_q <= StyleBand;
    end else if (cfg_we_i) begin
      style_q <= cfg_wdata_i;
    end
  end

  // column store: shift on a note, zero on a clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCols; i++) heights_q[i] <= '0;
    end else if (in_acc) begin
      if (action_i == ActClear) begin
        for (int i = 0; i < NumCols; i++) heights_q[i] <= '0;
      end else begin
        for (int i = NumCols - 1; i > 0; i--) heights_q[i] <= heights_q[i-1];
        heights_q[0] <= band_height(note_freq_i);
      end
    end
  end

  // band colour of the current note
  always_ff @(posedge clk_i) begin
    if (in_acc && action_i == ActNote) begin
      note_col_q <= band_color(note_freq_i);
    end
  end

  // pixel sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (in_acc && action_i == ActNote) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (advance) begin
      cnt_q <= cnt_q + PixCntW'(1);
      if (cnt_q == PixCntW'(PixCnt - 1)) busy_q <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      pix_x_q     <= cur_x;
      pix_y_q     <= cur_y;
      pix_col_q   <= pix_col_d;
      frame_end_q <= (cnt_q == PixCntW'(PixCnt - 1));
    end
  end

  assign in_stall_o  = busy_q;
  assign out_valid_o = out_valid_q;
  assign pix_x_o     = pix_x_q;
  assign pix_y_o     = pix_y_q;
  assign red_o       = pix_col_q.red;
  assign green_o     = pix_col_q.green;
  assign blue_o      = pix_col_q.blue;
  assign frame_end_o = frame_end_q;

endmodule

/* hdl/snbd_grad.sv */
// Gradient shader: one shared 8x8 multiplier scales the green base by the x ramp.
module snbd_grad (
  input  logic [snbd_pkg::ColW-1:0] x_i,
  input  logic [snbd_pkg::ColW-1:0] y_i,
  output snbd_pkg::rgb_t            color_o
);
  import snbd_pkg::*;

  logic [ColW-1:0]    rise;
  logic [ChanW-1:0]   lum;
  logic [ChanW-1:0]   base_g;
  logic [2*ChanW-1:0] prod;

  assign rise   = ~y_i;            // 7 - y
  assign lum    = LumRamp[x_i];
  assign base_g = GradGreen[rise];
  assign prod   = base_g * lum;

  // red base is 255: (255*lum) >> 8 equals lum - 1 for lum in 1..255
  assign color_o.red   = lum - 8'd1;
  assign color_o.green = prod[2*ChanW-1:ChanW];
  assign color_o.blue  = '0;

endmodule
